FILE: src/window_log_merge_core_defines.svh
// Assertion macros used by the checker file.
`ifndef WINDOW_LOG_MERGE_CORE_DEFINES_SVH
`define WINDOW_LOG_MERGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define WLM_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define WLM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/wlm_pkg.sv
// ----------------------------------------------------------------------------
// wlm_pkg
// Shared constants, types and codes of the window log merge core.
// ----------------------------------------------------------------------------
package wlm_pkg;

	localparam int NUM_WINDOWS = 16;
	localparam int LOG_DEPTH   = 1024;
	localparam int QDEPTH      = 2;

	localparam int WIX_W  = $clog2(NUM_WINDOWS);
	localparam int SLOT_W = $clog2(LOG_DEPTH);
	localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
	localparam int ADDR_W = WIX_W + SLOT_W;
	localparam int QIX_W  = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] ACT_RECORD = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_NEXT   = 2'd2;

	localparam logic [1:0] STAT_RECORDED  = 2'd0;
	localparam logic [1:0] STAT_STARTED   = 2'd1;
	localparam logic [1:0] STAT_MERGED    = 2'd2;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

	typedef enum logic [2:0] {
		CMD_RECORD = 3'b001,
		CMD_START  = 3'b010,
		CMD_NEXT   = 3'b100
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  window;
		logic [26:0] day;
		logic [24:0] tod;
		logic [31:0] student;
		logic [31:0] card;
		logic [23:0] amount;
	} cmd_t;

	typedef struct packed {
		logic [26:0] day;
		logic [24:0] tod;
		logic [31:0] student;
		logic [31:0] card;
		logic [23:0] amount;
	} log_entry_t;

endpackage

FILE: src/wlm_front.sv
// ----------------------------------------------------------------------------
// wlm_front
// Accepts requests, decodes the action and pushes commands to the queue.
// ----------------------------------------------------------------------------
module wlm_front (
	input  logic               start,
	input  logic [1:0]         action,
	input  logic [3:0]         window,
	input  logic [26:0]        day_stamp,
	input  logic [24:0]        time_stamp,
	input  logic [31:0]        student_id,
	input  logic [31:0]        card_number,
	input  logic [23:0]        payment_cents,
	input  logic               q_full,
	output logic               busy,
	output logic               push,
	output wlm_pkg::cmd_t      cmd
);
	import wlm_pkg::*;

	logic      known;
	cmd_kind_t kind;

	always_comb begin
		known = 1'b1;
		kind  = CMD_RECORD;
		unique case (action)
			ACT_RECORD: kind = CMD_RECORD;
			ACT_START:  kind = CMD_START;
			ACT_NEXT:   kind = CMD_NEXT;
			default:    known = 1'b0;
		endcase
	end

	assign cmd = '{kind: kind, window: window, day: day_stamp, tod: time_stamp,
		student: student_id, card: card_number, amount: payment_cents};

	assign busy = q_full;
	// drop unknown actions
	assign push = start && !q_full && known;

endmodule

FILE: src/wlm_queue.sv
// ----------------------------------------------------------------------------
// wlm_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module wlm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wlm_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output wlm_pkg::cmd_t head
);
	import wlm_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QIX_W-1:0]  wr_q;
	logic [QIX_W-1:0]  rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QIX_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == QIX_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: src/wlm_back.sv
// ----------------------------------------------------------------------------
// wlm_back
// Executes commands: logs records, arms cursors, scans window heads.
// ----------------------------------------------------------------------------
module wlm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  wlm_pkg::cmd_t q_head,
	output logic          pop,
	output logic          done,
	output logic [1:0]    status,
	output logic [3:0]    out_window,
	output logic [26:0]   out_day,
	output logic [24:0]   out_time,
	output logic [31:0]   out_student,
	output logic [31:0]   out_card,
	output logic [23:0]   out_amount,
	output logic [31:0]   today_count,
	output logic [39:0]   today_total
);
	import wlm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	log_entry_t mem [NUM_WINDOWS * (2 ** SLOT_W)];

	logic [SLOT_W-1:0] oldest_q [NUM_WINDOWS];
	logic [CNT_W-1:0]  fill_q   [NUM_WINDOWS];
	logic [26:0]       lday_q   [NUM_WINDOWS];
	logic [31:0]       dcnt_q   [NUM_WINDOWS];
	logic [39:0]       dtot_q   [NUM_WINDOWS];
	logic [CNT_W-1:0]  mrem_q   [NUM_WINDOWS];
	logic [SLOT_W-1:0] mslot_q  [NUM_WINDOWS];

	logic [WIX_W-1:0]  scan_q;
	logic              rd_v_q;
	logic [WIX_W-1:0]  rd_w_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [CNT_W-1:0]  rd_rem_q;
	log_entry_t        rdata_q;
	logic              found_q;
	logic [WIX_W-1:0]  best_w_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [CNT_W-1:0]  best_rem_q;
	log_entry_t        best_q;

	logic              done_q;
	logic [1:0]        status_q;
	logic [3:0]        win_q;
	log_entry_t        res_q;
	logic [31:0]       cnt_out_q;
	logic [39:0]       tot_out_q;

	logic [WIX_W-1:0]  widx;
	logic              in_range;
	logic              same_day;
	logic [31:0]       new_cnt;
	logic [40:0]       tot_sum;
	logic [39:0]       new_tot;
	logic [CNT_W:0]    pos_sum;
	logic [SLOT_W-1:0] wr_slot;
	logic              is_full;
	logic              scan_live;
	logic              take;
	log_entry_t        wr_ent;

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign widx     = WIX_W'(q_head.window);
	assign in_range = (32'(q_head.window) < NUM_WINDOWS);
	assign same_day = (lday_q[widx] == q_head.day);
	assign is_full  = (fill_q[widx] >= CNT_W'(LOG_DEPTH));

	always_comb begin
		if (!same_day) begin
			new_cnt = 32'd1;
			new_tot = 40'(q_head.amount);
			tot_sum = '0;
		end else begin
			new_cnt = (dcnt_q[widx] == '1) ? dcnt_q[widx] : dcnt_q[widx] + 32'd1;
			tot_sum = {1'b0, dtot_q[widx]} + 41'(q_head.amount);
			new_tot = tot_sum[40] ? '1 : tot_sum[39:0];
		end
		pos_sum = (CNT_W + 1)'(oldest_q[widx]) + (CNT_W + 1)'(fill_q[widx]);
		if (is_full)
			wr_slot = oldest_q[widx];
		else if (pos_sum >= (CNT_W + 1)'(LOG_DEPTH))
			wr_slot = SLOT_W'(pos_sum - (CNT_W + 1)'(LOG_DEPTH));
		else
			wr_slot = SLOT_W'(pos_sum);
	end

	assign wr_ent    = '{day: q_head.day, tod: q_head.tod, student: q_head.student,
		card: q_head.card, amount: q_head.amount};
	assign scan_live = (mrem_q[scan_q] != '0);
	assign take      = rd_v_q && (!found_q ||
		({rdata_q.day, rdata_q.tod} < {best_q.day, best_q.tod}));

	always_ff @(posedge clk) begin
		if (pop && q_head.kind == CMD_RECORD && in_range)
			mem[{widx, wr_slot}] <= wr_ent;
		if (state_q == ST_SCAN)
			rdata_q <= mem[{scan_q, mslot_q[scan_q]}];
		rd_w_q    <= scan_q;
		rd_slot_q <= mslot_q[scan_q];
		rd_rem_q  <= mrem_q[scan_q];
		if (take) begin
			best_q      <= rdata_q;
			best_w_q    <= rd_w_q;
			best_slot_q <= rd_slot_q;
			best_rem_q  <= rd_rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			rd_v_q  <= 1'b0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
			for (int w = 0; w < NUM_WINDOWS; w++) begin
				oldest_q[w] <= '0;
				fill_q[w]   <= '0;
				lday_q[w]   <= '0;
				dcnt_q[w]   <= '0;
				dtot_q[w]   <= '0;
				mrem_q[w]   <= '0;
				mslot_q[w]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			rd_v_q <= 1'b0;
			if (take) found_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (q_head.kind)
							CMD_RECORD: begin
								done_q    <= 1'b1;
								status_q  <= STAT_RECORDED;
								win_q     <= q_head.window;
								res_q     <= '0;
								cnt_out_q <= '0;
								tot_out_q <= '0;
								if (in_range) begin
									for (int w = 0; w < NUM_WINDOWS; w++) mrem_q[w] <= '0;
									lday_q[widx] <= q_head.day;
									dcnt_q[widx] <= new_cnt;
									dtot_q[widx] <= new_tot;
									cnt_out_q    <= new_cnt;
									tot_out_q    <= new_tot;
									if (is_full)
										oldest_q[widx] <= (oldest_q[widx] ==
											SLOT_W'(LOG_DEPTH - 1)) ? '0 : oldest_q[widx] + 1'b1;
									else
										fill_q[widx] <= fill_q[widx] + 1'b1;
								end
							end
							CMD_START: begin
								for (int w = 0; w < NUM_WINDOWS; w++) begin
									mslot_q[w] <= oldest_q[w];
									mrem_q[w]  <= fill_q[w];
								end
								done_q    <= 1'b1;
								status_q  <= STAT_STARTED;
								win_q     <= '0;
								res_q     <= '0;
								cnt_out_q <= '0;
								tot_out_q <= '0;
							end
							CMD_NEXT: begin
								scan_q  <= '0;
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					rd_v_q <= scan_live;
					if (scan_q == WIX_W'(NUM_WINDOWS - 1)) state_q <= ST_DRAIN;
					else scan_q <= scan_q + 1'b1;
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					done_q    <= 1'b1;
					cnt_out_q <= '0;
					tot_out_q <= '0;
					if (found_q) begin
						status_q <= STAT_MERGED;
						win_q    <= 4'(best_w_q);
						res_q    <= best_q;
						mrem_q[best_w_q]  <= best_rem_q - 1'b1;
						mslot_q[best_w_q] <= (best_slot_q == SLOT_W'(LOG_DEPTH - 1)) ?
							'0 : best_slot_q + 1'b1;
					end else begin
						status_q <= STAT_EXHAUSTED;
						win_q    <= '0;
						res_q    <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_window  = win_q;
	assign out_day     = res_q.day;
	assign out_time    = res_q.tod;
	assign out_student = res_q.student;
	assign out_card    = res_q.card;
	assign out_amount  = res_q.amount;
	assign today_count = cnt_out_q;
	assign today_total = tot_out_q;

endmodule

FILE: src/window_log_merge_core.sv
// ----------------------------------------------------------------------------
// window_log_merge_core
// Per-window ring logs of payment records with a k-way merged read-out.
// ----------------------------------------------------------------------------
// Usage: drive the request fields and raise start; the request is taken at a
// clock edge where start is high and busy is low. Action 3 is dropped.
// Requests enter a two-entry queue, so busy rises only when it is full.
// Each record, start or next request yields one result, shown for one cycle
// with done high. Record and start results pass the queue and result registers.
// A next request scans every window head through the log memory read port,
// one window per cycle; no other request is executed until its result shows.
// Records and starts are executed one per cycle while no next is in progress.
// Reset clears the queue, the window counters and the merge cursors;
// log memory contents are not cleared and need no clearing pass.
// The receiver cannot stall: each result must be taken the cycle it shows.
// ----------------------------------------------------------------------------
module window_log_merge_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [3:0]  window,
	input  logic [26:0] day_stamp,
	input  logic [24:0] time_stamp,
	input  logic [31:0] student_id,
	input  logic [31:0] card_number,
	input  logic [23:0] payment_cents,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  out_window,
	output logic [26:0] out_day,
	output logic [24:0] out_time,
	output logic [31:0] out_student,
	output logic [31:0] out_card,
	output logic [23:0] out_amount,
	output logic [31:0] today_count,
	output logic [39:0] today_total
);
	import wlm_pkg::*;

	logic push, q_full, q_empty, pop;
	cmd_t cmd, head;

	wlm_front u_front (
		.start, .action, .window, .day_stamp, .time_stamp, .student_id,
		.card_number, .payment_cents, .q_full, .busy, .push, .cmd
	);

	wlm_queue u_queue (
		.clk, .arst_n, .push, .push_cmd(cmd), .pop, .full(q_full),
		.empty(q_empty), .head
	);

	wlm_back u_back (
		.clk, .arst_n, .q_empty, .q_head(head), .pop, .done, .status,
		.out_window, .out_day, .out_time, .out_student, .out_card,
		.out_amount, .today_count, .today_total
	);

endmodule

FILE: src/wlm_checker.sv
// ----------------------------------------------------------------------------
// wlm_checker
// Port-level checks of the window log merge core.
// ----------------------------------------------------------------------------
`include "window_log_merge_core_defines.svh"

module wlm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic [1:0]  status,
	input logic [3:0]  out_window,
	input logic [26:0] out_day,
	input logic [31:0] today_count,
	input logic [39:0] today_total
);
	import wlm_pkg::*;

	`WLM_ASSERT_NOW(a_start_clean, clk, arst_n, done && status == STAT_STARTED, out_window == 4'd0 && today_count == 32'd0 && out_day == 27'd0)
	`WLM_ASSERT_NOW(a_merged_no_day, clk, arst_n, done && status == STAT_MERGED, today_count == 32'd0 && today_total == 40'd0)
	`WLM_ASSERT_NOW(a_record_count, clk, arst_n, done && status == STAT_RECORDED, today_count != 32'd0 && out_day == 27'd0)
	`WLM_ASSERT_NEXT(a_single_pulse, clk, arst_n, done && status == STAT_EXHAUSTED, !done || status != STAT_EXHAUSTED)

endmodule

bind window_log_merge_core wlm_checker u_wlm_checker (.*);
